[hdl/pidsw_pkg.sv]
// Package for the speed-weighted PID controller.
// Holds field widths, register indexes and the datapath widths
// shared by the top level and the multiplier.
package pidsw_pkg;

  localparam int unsigned ErrW    = 16;  // track_error, signed Q8.8
  localparam int unsigned SpeedW  = 9;   // speed_weight, unsigned Q1.8
  localparam int unsigned GainW   = 16;  // gains, signed Q8.8
  localparam int unsigned SumW    = 32;  // error_sum
  localparam int unsigned DiffW   = ErrW + 1;
  localparam int unsigned OutW    = 16;  // drive_value, signed Q8.8

  // Shared multiplier operands and the kept product width
  localparam int unsigned MulAW   = 48;
  localparam int unsigned MulBW   = 17;
  localparam int unsigned ProdW   = 58;
  localparam int unsigned AccW    = 58;

  localparam int unsigned InDataW = 32;  // 25 field bits padded to bytes
  localparam int unsigned CfgIdxW = 2;

  localparam logic [SpeedW-1:0] SpeedOne = SpeedW'(256);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegGainProp  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGainInteg = 2'd1;
  localparam logic [CfgIdxW-1:0] RegGainDeriv = 2'd2;

endpackage

[hdl/pidsw_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on pidsw_pkg for operand and product widths.
module pidsw_mul (
  input  logic                              clk,
  input  logic signed [pidsw_pkg::MulAW-1:0] op_a,
  input  logic signed [pidsw_pkg::MulBW-1:0] op_b,
  output logic signed [pidsw_pkg::ProdW-1:0] prod_r
);
  import pidsw_pkg::*;

  logic signed [MulAW+MulBW-1:0] full_prod;

  // Form the full product; every value used here fits the kept width
  assign full_prod = op_a * op_b;

  // Register the product
  always_ff @(posedge clk) begin
    prod_r <= full_prod[ProdW-1:0];
  end

endmodule

[hdl/pid_speed_weighted_controller_unit.sv]
// Top level of the speed-weighted PID controller.
// Depends on pidsw_pkg and the shared multiplier pidsw_mul.
//
// Usage:
//   Input stream (in_*): one request per control sample, carrying the
//   cross-track error and the speed factor. Output stream (out_*): one
//   controller drive value per request, in order.
//   Configuration port (cfg_*): write the three gains while the block is
//   idle; index 0 is Kp, 1 is Ki, 2 is Kd. Other indexes are ignored.
//   Sequencing: a request is taken in the idle state, then one
//   shared 48x17 multiplier is run five times under a small sequencer
//   (Kp*e, times s, Kd*d, Ki*sum, times 1-s) with the adds folded in,
//   followed by a rounding step that writes the output register. A new
//   request is taken only after the previous one has left the sequencer.
//   in_tready is high only while the sequencer is idle; the next request
//   is taken while a finished result still waits in the output register.
//   If the receiver stalls, the result holds on out_tdata and a following
//   request finishes its work but waits in its last step until the output
//   register frees up.
//   Reset: gains, previous error and integral clear to zero; no result is
//   pending.
module pid_speed_weighted_controller_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // [15:0] track_error, [24:16] speed_weight, [31:25] zero
  input  logic [pidsw_pkg::InDataW-1:0]       in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [15:0] drive_value
  output logic [pidsw_pkg::OutW-1:0]          out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_wr_en,
  input  logic [pidsw_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [pidsw_pkg::GainW-1:0]         cfg_wdata
);
  import pidsw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_PE,
    ST_MUL_PS,
    ST_MUL_D,
    ST_MUL_I,
    ST_MUL_IW,
    ST_ACC,
    ST_OUT
  } state_t;

  state_t state_r;

  logic signed [GainW-1:0]  gain_prop_r, gain_integ_r, gain_deriv_r;
  logic signed [ErrW-1:0]   prev_err_r;
  logic signed [SumW-1:0]   err_sum_r;

  // Per-request working registers
  logic signed [ErrW-1:0]   err_r;
  logic signed [DiffW-1:0]  diff_r;
  logic [SpeedW-1:0]        speed_r;
  logic [SpeedW-1:0]        speed_inv_r;
  logic signed [AccW-1:0]   acc_r;
  logic [OutW-1:0]          out_data_r;
  logic                     out_valid_r;

  logic signed [MulAW-1:0]  op_a;
  logic signed [MulBW-1:0]  op_b;
  logic signed [ProdW-1:0]  prod_r;

  logic signed [ErrW-1:0]   in_err;
  logic [SpeedW-1:0]        in_speed;
  logic [SpeedW-1:0]        speed_sat;
  logic signed [SumW:0]     sum_wide;
  logic signed [SumW-1:0]   sum_sat;
  logic signed [AccW-1:0]   total;
  logic signed [AccW-17:0]  quot;
  logic [OutW-1:0]          drive;
  logic                     in_fire;
  logic                     out_free;

  assign in_err    = in_tdata[ErrW-1:0];
  assign in_speed  = in_tdata[ErrW +: SpeedW];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

  // Clamp speed to one and saturate the integral
  always_comb begin
    speed_sat = (in_speed > SpeedOne) ? SpeedOne : in_speed;
    sum_wide  = {err_sum_r[SumW-1], err_sum_r} + {{(SumW+1-ErrW){in_err[ErrW-1]}}, in_err};
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      sum_sat = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SumW-1:0];
    end
  end

  // Select multiplier operands for each step
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      ST_MUL_PE: begin
        op_a = MulAW'(gain_prop_r);
        op_b = MulBW'(err_r);
      end
      ST_MUL_PS: begin
        op_a = prod_r[MulAW-1:0];
        op_b = {{(MulBW-SpeedW){1'b0}}, speed_r};
      end
      ST_MUL_D: begin
        op_a = MulAW'(gain_deriv_r);
        op_b = diff_r;
      end
      ST_MUL_I: begin
        op_a = MulAW'(err_sum_r);
        op_b = MulBW'(gain_integ_r);
      end
      ST_MUL_IW: begin
        op_a = prod_r[MulAW-1:0];
        op_b = {{(MulBW-SpeedW){1'b0}}, speed_inv_r};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  pidsw_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // Negate, round half up to Q8.8 and saturate
  always_comb begin
    total = -acc_r + AccW'(32768);
    quot  = total[AccW-1:16];
    if (quot > (AccW-16)'(32767)) begin
      drive = 16'h7fff;
    end else if (quot < -(AccW-16)'(32768)) begin
      drive = 16'h8000;
    end else begin
      drive = quot[OutW-1:0];
    end
  end

  // Sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      gain_prop_r  <= '0;
      gain_integ_r <= '0;
      gain_deriv_r <= '0;
      prev_err_r   <= '0;
      err_sum_r    <= '0;
    end else begin
      // Take gain writes
      if (cfg_wr_en) begin
        case (cfg_index)
          RegGainProp:  gain_prop_r  <= cfg_wdata;
          RegGainInteg: gain_integ_r <= cfg_wdata;
          RegGainDeriv: gain_deriv_r <= cfg_wdata;
          default: ;
        endcase
      end

      // Drop the result once taken, unless a new one replaces it
      if (out_valid_r && out_tready && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            err_r       <= in_err;
            diff_r      <= DiffW'(in_err) - DiffW'(prev_err_r);
            speed_r     <= speed_sat;
            speed_inv_r <= SpeedOne - speed_sat;
            err_sum_r   <= sum_sat;
            prev_err_r  <= in_err;
            state_r     <= ST_MUL_PE;
          end
        end
        ST_MUL_PE: state_r <= ST_MUL_PS;
        ST_MUL_PS: state_r <= ST_MUL_D;
        ST_MUL_D: begin
          acc_r   <= prod_r;
          state_r <= ST_MUL_I;
        end
        ST_MUL_I: begin
          acc_r   <= acc_r + (prod_r <<< 8);
          state_r <= ST_MUL_IW;
        end
        ST_MUL_IW: state_r <= ST_ACC;
        ST_ACC: begin
          acc_r   <= acc_r + prod_r;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          // Hold until the output register is free
          if (out_free) begin
            out_data_r  <= drive;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
